// ===== design/cps_pkg.sv =====
// shared types and constants of the cpu process scheduler
package cps_pkg;

    localparam int VAL_W     = 16;
    localparam int TIME_W    = 21;
    localparam int PID_W     = 4;
    localparam int OP_W      = 2;
    localparam int ALG_W     = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SLICE = 2'd2
    } op_t;

    typedef enum logic [ALG_W-1:0] {
        ALG_FCFS = 2'd0,
        ALG_SJF  = 2'd1,
        ALG_RR   = 2'd2
    } alg_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM   = 1'd1;

    localparam logic [ALG_W-1:0] ALG_RESET     = ALG_FCFS;
    localparam logic [VAL_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic clear;
        logic eval;
        logic done;
    } scan_ctl_t;

    typedef struct packed {
        logic sjf_found;
        logic rr_hi_found;
        logic rr_lo_found;
    } scan_flags_t;

endpackage

// ===== design/cps_in_if.sv =====
// request channel: operation and process fields
interface cps_in_if import cps_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [VAL_W-1:0] arrival_time;
    logic [VAL_W-1:0] burst_length;

    modport source (output valid, output operation, output arrival_time,
                    output burst_length, input ready);
    modport sink (input valid, input operation, input arrival_time,
                  input burst_length, output ready);

endinterface

// ===== design/cps_out_if.sv =====
// result channel: one schedule slice
interface cps_out_if import cps_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [TIME_W-1:0] start_time;
    logic [VAL_W-1:0]  run_length;
    logic [TIME_W-1:0] end_time;
    logic              completes;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              schedule_done;
    logic              no_work;

    modport source (output valid, output process_id, output start_time,
                    output run_length, output end_time, output completes,
                    output turnaround, output waiting, output schedule_done,
                    output no_work, input ready);
    modport sink (input valid, input process_id, input start_time,
                  input run_length, input end_time, input completes,
                  input turnaround, input waiting, input schedule_done,
                  input no_work, output ready);

endinterface

// ===== design/cps_ram.sv =====
// generic single write port ram with registered read
module cps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cps_scan.sv =====
// table scan unit: evaluates one entry per cycle and keeps the running picks
module cps_scan import cps_pkg::*; #(
    parameter int IDX_W = 4,
    parameter int CLK_W = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  logic [IDX_W-1:0] idx,
    input  logic [IDX_W-1:0] start_ptr,
    input  logic [VAL_W-1:0] arrival,
    input  logic [VAL_W-1:0] burst,
    input  logic [CLK_W-1:0] clock_now,
    output scan_flags_t      flags,
    output logic [VAL_W-1:0] early_arrival,
    output logic [IDX_W-1:0] early_id,
    output logic [IDX_W-1:0] early_short_id,
    output logic [IDX_W-1:0] sjf_id,
    output logic [IDX_W-1:0] rr_hi_id,
    output logic [IDX_W-1:0] rr_lo_id
);

    logic             pend_reg, pend_next;
    logic [VAL_W-1:0] e_arr_reg, e_arr_next;
    logic [IDX_W-1:0] e_id_reg, e_id_next;
    logic [VAL_W-1:0] eb_burst_reg, eb_burst_next;
    logic [IDX_W-1:0] eb_id_reg, eb_id_next;
    logic             sj_found_reg, sj_found_next;
    logic [VAL_W-1:0] sj_burst_reg, sj_burst_next;
    logic [IDX_W-1:0] sj_id_reg, sj_id_next;
    logic             hi_found_reg, hi_found_next;
    logic [IDX_W-1:0] hi_id_reg, hi_id_next;
    logic             lo_found_reg, lo_found_next;
    logic [IDX_W-1:0] lo_id_reg, lo_id_next;
    logic             pending;
    logic             is_ready;

    always_comb
    begin
        pend_next     = pend_reg;
        e_arr_next    = e_arr_reg;
        e_id_next     = e_id_reg;
        eb_burst_next = eb_burst_reg;
        eb_id_next    = eb_id_reg;
        sj_found_next = sj_found_reg;
        sj_burst_next = sj_burst_reg;
        sj_id_next    = sj_id_reg;
        hi_found_next = hi_found_reg;
        hi_id_next    = hi_id_reg;
        lo_found_next = lo_found_reg;
        lo_id_next    = lo_id_reg;
        pending       = ctl.eval && !ctl.done;
        is_ready      = pending && (CLK_W'(arrival) <= clock_now);

        if (ctl.clear)
        begin
            pend_next     = 1'b0;
            sj_found_next = 1'b0;
            hi_found_next = 1'b0;
            lo_found_next = 1'b0;
        end
        else
        begin
            if (pending)
            begin
                // earliest arrival, and shortest burst among those tied with it
                if (!pend_reg || arrival < e_arr_reg)
                begin
                    pend_next     = 1'b1;
                    e_arr_next    = arrival;
                    e_id_next     = idx;
                    eb_burst_next = burst;
                    eb_id_next    = idx;
                end
                else if (arrival == e_arr_reg && burst < eb_burst_reg)
                begin
                    eb_burst_next = burst;
                    eb_id_next    = idx;
                end
            end
            if (is_ready)
            begin
                if (!sj_found_reg || burst < sj_burst_reg)
                begin
                    sj_found_next = 1'b1;
                    sj_burst_next = burst;
                    sj_id_next    = idx;
                end
                if (!lo_found_reg)
                begin
                    lo_found_next = 1'b1;
                    lo_id_next    = idx;
                end
                if (!hi_found_reg && idx >= start_ptr)
                begin
                    hi_found_next = 1'b1;
                    hi_id_next    = idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            e_arr_reg    <= '0;
            e_id_reg     <= '0;
            eb_burst_reg <= '0;
            eb_id_reg    <= '0;
            sj_found_reg <= 1'b0;
            sj_burst_reg <= '0;
            sj_id_reg    <= '0;
            hi_found_reg <= 1'b0;
            hi_id_reg    <= '0;
            lo_found_reg <= 1'b0;
            lo_id_reg    <= '0;
        end
        else
        begin
            pend_reg     <= pend_next;
            e_arr_reg    <= e_arr_next;
            e_id_reg     <= e_id_next;
            eb_burst_reg <= eb_burst_next;
            eb_id_reg    <= eb_id_next;
            sj_found_reg <= sj_found_next;
            sj_burst_reg <= sj_burst_next;
            sj_id_reg    <= sj_id_next;
            hi_found_reg <= hi_found_next;
            hi_id_reg    <= hi_id_next;
            lo_found_reg <= lo_found_next;
            lo_id_reg    <= lo_id_next;
        end
    end

    assign flags.sjf_found   = sj_found_reg;
    assign flags.rr_hi_found = hi_found_reg;
    assign flags.rr_lo_found = lo_found_reg;
    assign early_arrival     = e_arr_reg;
    assign early_id          = e_id_reg;
    assign early_short_id    = eb_id_reg;
    assign sjf_id            = sj_id_reg;
    assign rr_hi_id          = hi_id_reg;
    assign rr_lo_id          = lo_id_reg;

endmodule

// ===== design/cpu_process_scheduler_top.sv =====
// cpu process scheduler top: sequencer, process table and slice arithmetic
// clear and load transactions finish as they are accepted; a slice request with nothing left
// returns its result in the cycle after acceptance
// a slice request goes one table entry per cycle through the scan unit, then through the
// last, decide, read, run, tat and wait states for pick, read and update arithmetic
// one transaction at a time; the next is accepted once the result is taken
// reset empties the table, zeroes the clock and scan pointer, mode fcfs, quantum 4
module cpu_process_scheduler_top import cps_pkg::*; #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_wr_data,
    cps_in_if.sink               cmd,
    cps_out_if.source            rsp
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int CLK_W = VAL_W + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_READ,
        S_RUN,
        S_TAT,
        S_WAIT,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [ALG_W-1:0]     alg_reg, alg_next;
    logic [VAL_W-1:0]     quantum_reg, quantum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     fin_reg, fin_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [IDX_W-1:0]     sp_reg, sp_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0]     sel_reg, sel_next;
    logic [VAL_W-1:0]     arr_reg, arr_next;
    logic [VAL_W-1:0]     burst_reg, burst_next;
    logic [VAL_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]     run_reg, run_next;
    logic [CLK_W-1:0]     start_reg, start_next;
    logic [CLK_W-1:0]     end_reg, end_next;
    logic                 comp_reg, comp_next;
    logic [CLK_W-1:0]     tat_reg, tat_next;

    logic [PID_W-1:0]     o_pid_reg, o_pid_next;
    logic [TIME_W-1:0]    o_start_reg, o_start_next;
    logic [VAL_W-1:0]     o_run_reg, o_run_next;
    logic [TIME_W-1:0]    o_end_reg, o_end_next;
    logic                 o_comp_reg, o_comp_next;
    logic [TIME_W-1:0]    o_tat_reg, o_tat_next;
    logic [TIME_W-1:0]    o_wait_reg, o_wait_next;
    logic                 o_sdone_reg, o_sdone_next;
    logic                 o_nowork_reg, o_nowork_next;

    logic                 load_we;
    logic                 rem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;
    logic [VAL_W-1:0]     burst_in;
    logic [VAL_W-1:0]     rem_wdata;
    logic [VAL_W-1:0]     arr_rd;
    logic [VAL_W-1:0]     burst_rd;
    logic [VAL_W-1:0]     rem_rd;
    logic [VAL_W-1:0]     q_eff;
    logic                 is_rr;

    scan_ctl_t            scan_ctl;
    scan_flags_t          scan_flags;
    logic [VAL_W-1:0]     early_arrival;
    logic [IDX_W-1:0]     early_id;
    logic [IDX_W-1:0]     early_short_id;
    logic [IDX_W-1:0]     sjf_id;
    logic [IDX_W-1:0]     rr_hi_id;
    logic [IDX_W-1:0]     rr_lo_id;
    logic [IDX_W-1:0]     sel_pick;
    logic [CLK_W-1:0]     clk_pick;

    assign burst_in = (cmd.burst_length == '0) ? VAL_W'(1) : cmd.burst_length;
    assign q_eff    = (quantum_reg == '0) ? VAL_W'(1) : quantum_reg;
    assign is_rr    = (alg_reg != ALG_FCFS) && (alg_reg != ALG_SJF);

    cps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCESSES)) u_arrival_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (mem_waddr),
        .wdata (cmd.arrival_time),
        .raddr (mem_raddr),
        .rdata (arr_rd)
    );

    cps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCESSES)) u_burst_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (mem_waddr),
        .wdata (burst_in),
        .raddr (mem_raddr),
        .rdata (burst_rd)
    );

    cps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCESSES)) u_remaining_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (mem_waddr),
        .wdata (rem_wdata),
        .raddr (mem_raddr),
        .rdata (rem_rd)
    );

    cps_scan #(.IDX_W(IDX_W), .CLK_W(CLK_W)) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (scan_ctl),
        .idx            (ev_idx_reg),
        .start_ptr      (sp_reg),
        .arrival        (arr_rd),
        .burst          (burst_rd),
        .clock_now      (clock_reg),
        .flags          (scan_flags),
        .early_arrival  (early_arrival),
        .early_id       (early_id),
        .early_short_id (early_short_id),
        .sjf_id         (sjf_id),
        .rr_hi_id       (rr_hi_id),
        .rr_lo_id       (rr_lo_id)
    );

    // pick by mode once the scan has finished
    always_comb
    begin
        sel_pick = early_id;
        clk_pick = clock_reg;
        case (alg_reg)
            ALG_FCFS:
            begin
                sel_pick = early_id;
                if (CLK_W'(early_arrival) > clock_reg)
                begin
                    clk_pick = CLK_W'(early_arrival);
                end
            end
            ALG_SJF:
            begin
                if (scan_flags.sjf_found)
                begin
                    sel_pick = sjf_id;
                end
                else
                begin
                    sel_pick = early_short_id;
                    clk_pick = CLK_W'(early_arrival);
                end
            end
            default:
            begin
                if (scan_flags.rr_hi_found)
                begin
                    sel_pick = rr_hi_id;
                end
                else if (scan_flags.rr_lo_found)
                begin
                    sel_pick = rr_lo_id;
                end
                else
                begin
                    sel_pick = early_id;
                    clk_pick = CLK_W'(early_arrival);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        alg_next      = alg_reg;
        quantum_next  = quantum_reg;
        cnt_next      = cnt_reg;
        fin_next      = fin_reg;
        done_next     = done_reg;
        clock_next    = clock_reg;
        sp_next       = sp_reg;
        scan_idx_next = scan_idx_reg;
        ev_vld_next   = 1'b0;
        ev_idx_next   = ev_idx_reg;
        sel_next      = sel_reg;
        arr_next      = arr_reg;
        burst_next    = burst_reg;
        rem_next      = rem_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        comp_next     = comp_reg;
        tat_next      = tat_reg;
        o_pid_next    = o_pid_reg;
        o_start_next  = o_start_reg;
        o_run_next    = o_run_reg;
        o_end_next    = o_end_reg;
        o_comp_next   = o_comp_reg;
        o_tat_next    = o_tat_reg;
        o_wait_next   = o_wait_reg;
        o_sdone_next  = o_sdone_reg;
        o_nowork_next = o_nowork_reg;

        load_we        = 1'b0;
        rem_we         = 1'b0;
        mem_waddr      = sel_reg;
        rem_wdata      = rem_reg - run_reg;
        mem_raddr      = scan_idx_reg;
        scan_ctl.clear = 1'b0;
        scan_ctl.eval  = ev_vld_reg;
        scan_ctl.done  = done_reg[ev_idx_reg];

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ALGORITHM: alg_next = cfg_wr_data[ALG_W-1:0];
                CFG_QUANTUM:   quantum_next = cfg_wr_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (op_t'(cmd.operation))
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            fin_next   = '0;
                            done_next  = '0;
                            clock_next = '0;
                            sp_next    = '0;
                        end
                        OP_LOAD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_PROCESSES))
                            begin
                                load_we   = 1'b1;
                                rem_we    = 1'b1;
                                mem_waddr = cnt_reg[IDX_W-1:0];
                                rem_wdata = burst_in;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_SLICE:
                        begin
                            if (fin_reg >= cnt_reg)
                            begin
                                o_pid_next    = '0;
                                o_start_next  = '0;
                                o_run_next    = '0;
                                o_end_next    = '0;
                                o_comp_next   = 1'b0;
                                o_tat_next    = '0;
                                o_wait_next   = '0;
                                o_sdone_next  = 1'b0;
                                o_nowork_next = 1'b1;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                scan_idx_next  = '0;
                                scan_ctl.clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                ev_vld_next = 1'b1;
                ev_idx_next = scan_idx_reg;
                if (CNT_W'(scan_idx_reg) == cnt_reg - CNT_W'(1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                sel_next   = sel_pick;
                clock_next = clk_pick;
                mem_raddr  = sel_pick;
                state_next = S_READ;
            end
            S_READ:
            begin
                arr_next   = arr_rd;
                burst_next = burst_rd;
                rem_next   = rem_rd;
                run_next   = (is_rr && rem_rd > q_eff) ? q_eff : rem_rd;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                rem_we     = 1'b1;
                start_next = clock_reg;
                end_next   = clock_reg + CLK_W'(run_reg);
                clock_next = clock_reg + CLK_W'(run_reg);
                comp_next  = (rem_reg == run_reg);
                if (rem_reg == run_reg)
                begin
                    done_next[sel_reg] = 1'b1;
                    fin_next           = fin_reg + CNT_W'(1);
                end
                if (is_rr)
                begin
                    if (CNT_W'(sel_reg) + CNT_W'(1) == cnt_reg)
                    begin
                        sp_next = '0;
                    end
                    else
                    begin
                        sp_next = sel_reg + IDX_W'(1);
                    end
                end
                state_next = S_TAT;
            end
            S_TAT:
            begin
                tat_next   = end_reg - CLK_W'(arr_reg);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                o_pid_next    = PID_W'(sel_reg);
                o_start_next  = TIME_W'(start_reg);
                o_run_next    = run_reg;
                o_end_next    = TIME_W'(end_reg);
                o_comp_next   = comp_reg;
                o_tat_next    = comp_reg ? TIME_W'(tat_reg) : '0;
                o_wait_next   = '0;
                if (comp_reg && tat_reg >= CLK_W'(burst_reg))
                begin
                    o_wait_next = TIME_W'(tat_reg - CLK_W'(burst_reg));
                end
                o_sdone_next  = (fin_reg >= cnt_reg);
                o_nowork_next = 1'b0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            alg_reg      <= ALG_RESET;
            quantum_reg  <= QUANTUM_RESET;
            cnt_reg      <= '0;
            fin_reg      <= '0;
            done_reg     <= '0;
            clock_reg    <= '0;
            sp_reg       <= '0;
            scan_idx_reg <= '0;
            ev_vld_reg   <= 1'b0;
            ev_idx_reg   <= '0;
            sel_reg      <= '0;
            arr_reg      <= '0;
            burst_reg    <= '0;
            rem_reg      <= '0;
            run_reg      <= '0;
            start_reg    <= '0;
            end_reg      <= '0;
            comp_reg     <= 1'b0;
            tat_reg      <= '0;
            o_pid_reg    <= '0;
            o_start_reg  <= '0;
            o_run_reg    <= '0;
            o_end_reg    <= '0;
            o_comp_reg   <= 1'b0;
            o_tat_reg    <= '0;
            o_wait_reg   <= '0;
            o_sdone_reg  <= 1'b0;
            o_nowork_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            alg_reg      <= alg_next;
            quantum_reg  <= quantum_next;
            cnt_reg      <= cnt_next;
            fin_reg      <= fin_next;
            done_reg     <= done_next;
            clock_reg    <= clock_next;
            sp_reg       <= sp_next;
            scan_idx_reg <= scan_idx_next;
            ev_vld_reg   <= ev_vld_next;
            ev_idx_reg   <= ev_idx_next;
            sel_reg      <= sel_next;
            arr_reg      <= arr_next;
            burst_reg    <= burst_next;
            rem_reg      <= rem_next;
            run_reg      <= run_next;
            start_reg    <= start_next;
            end_reg      <= end_next;
            comp_reg     <= comp_next;
            tat_reg      <= tat_next;
            o_pid_reg    <= o_pid_next;
            o_start_reg  <= o_start_next;
            o_run_reg    <= o_run_next;
            o_end_reg    <= o_end_next;
            o_comp_reg   <= o_comp_next;
            o_tat_reg    <= o_tat_next;
            o_wait_reg   <= o_wait_next;
            o_sdone_reg  <= o_sdone_next;
            o_nowork_reg <= o_nowork_next;
        end
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = (state_reg == S_OUT);
    assign rsp.process_id    = o_pid_reg;
    assign rsp.start_time    = o_start_reg;
    assign rsp.run_length    = o_run_reg;
    assign rsp.end_time      = o_end_reg;
    assign rsp.completes     = o_comp_reg;
    assign rsp.turnaround    = o_tat_reg;
    assign rsp.waiting       = o_wait_reg;
    assign rsp.schedule_done = o_sdone_reg;
    assign rsp.no_work       = o_nowork_reg;

`ifndef SYNTHESIS
    // finished marks and finished count agree
    a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(done_reg) == int'(fin_reg)) && (fin_reg <= cnt_reg))
        else $error("finished count out of step with finished marks");

    // scan pointer stays inside the loaded table
    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (CNT_W'(sp_reg) < cnt_reg))
        else $error("scan pointer beyond loaded table");

    // a real slice always has a nonzero run length
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.no_work) |-> (rsp.run_length != '0))
        else $error("slice with zero run length");

    // a slice request on a finished table answers with no work next cycle
    a_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.operation == OP_SLICE && fin_reg >= cnt_reg)
        |=> (rsp.valid && rsp.no_work))
        else $error("missing no work result");

    // schedule done only when every loaded process finished
    a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.schedule_done) |-> (fin_reg == cnt_reg && rsp.completes))
        else $error("schedule done reported early");
`endif

endmodule
